// File: rtl/vsa_pkg.sv
package vsa_pkg;

    localparam int ID_W       = 32;
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 2;
    localparam int SLOT_OUT_W = 5;
    localparam int SLOTS_DEF  = 8;

    localparam logic [MODE_W-1:0] MODE_STEAL    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOP_ALL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IF_FREE  = 2'd2;
    // Unused code; the block treats it as steal-oldest.
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    localparam logic FUNC_PLAY    = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_STOP     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLACED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REFUSED  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd3;

    typedef struct packed {
        logic            shift;
        logic [ID_W-1:0] tail;
    } ring_ctrl_t;

    typedef struct packed {
        logic [ID_W-1:0] head;
        logic [ID_W-1:0] next;
    } ring_view_t;

endpackage

// File: rtl/vsa_slot_ring.sv
module vsa_slot_ring
    import vsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ring_ctrl_t ring_ctl,
    output ring_view_t ring_view
);

    logic [ID_W-1:0] slot_reg [SLOTS];

    // Rotate the row by one slot: head leaves, the new value enters at the tail.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                slot_reg[j] <= '0;
            end
        end
        else if (ring_ctl.shift)
        begin
            for (int j = 0; j < SLOTS - 1; j++)
            begin
                slot_reg[j] <= slot_reg[j+1];
            end
            slot_reg[SLOTS-1] <= ring_ctl.tail;
        end
    end

    assign ring_view.head = slot_reg[0];
    assign ring_view.next = slot_reg[1];

endmodule

// File: rtl/vsa_ctrl.sv
module vsa_ctrl
    import vsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [ID_W-1:0]       voice_id,
    input  logic                  mode_we,
    input  logic [MODE_W-1:0]     mode_wdata,
    input  ring_view_t            ring_view,
    output ring_ctrl_t            ring_ctl,
    output logic                  strobe,
    output logic [KIND_W-1:0]     kind,
    output logic [ID_W-1:0]       stop_id,
    output logic [SLOT_OUT_W-1:0] slot,
    output logic                  last
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] CNT_LAST = SLOT_W'(SLOTS - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_SCAN2  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    localparam logic [1:0] OP_RELEASE  = 2'd0;
    localparam logic [1:0] OP_STOP_ALL = 2'd1;
    localparam logic [1:0] OP_IF_FREE  = 2'd2;
    localparam logic [1:0] OP_STEAL    = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [SLOT_W-1:0]     cnt_reg, cnt_next;
    logic                  found_reg, found_next;
    logic [SLOT_W-1:0]     hit_slot_reg, hit_slot_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [MODE_W-1:0]     mode_reg;

    logic                  strobe_reg, strobe_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [ID_W-1:0]       stop_id_reg, stop_id_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic                  last_reg, last_next;

    logic [ID_W-1:0]       cmp_operand;
    logic                  hit;
    logic                  take;
    logic                  at_end;

    // Shared comparator: release looks for the ended id, every other op for a free slot.
    assign cmp_operand = (op_reg == OP_RELEASE) ? id_reg : '0;
    assign hit         = (ring_view.head == cmp_operand);
    assign at_end      = (cnt_reg == CNT_LAST);
    assign take        = found_reg || hit || (state_reg == S_SCAN2 && cnt_reg == '0);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        hit_slot_next = hit_slot_reg;
        id_next       = id_reg;
        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        stop_id_next  = stop_id_reg;
        slot_next     = slot_reg;
        last_next     = last_reg;
        ring_ctl.shift = 1'b0;
        ring_ctl.tail  = ring_view.head;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    id_next    = voice_id;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                    if (func == FUNC_RELEASE)
                    begin
                        op_next = OP_RELEASE;
                    end
                    else if (mode_reg == MODE_STOP_ALL)
                    begin
                        op_next = OP_STOP_ALL;
                    end
                    else if (mode_reg == MODE_IF_FREE)
                    begin
                        op_next = OP_IF_FREE;
                    end
                    else
                    begin
                        op_next = OP_STEAL;
                    end
                end
            end
            S_SCAN, S_SCAN2:
            begin
                ring_ctl.shift = 1'b1;
                unique case (op_reg)
                    OP_RELEASE:
                    begin
                        ring_ctl.tail = hit ? '0 : ring_view.head;
                    end
                    OP_STOP_ALL:
                    begin
                        // The value written at step zero comes back round to slot zero.
                        ring_ctl.tail = (cnt_reg == '0) ? id_reg : '0;
                        if (!hit)
                        begin
                            strobe_next  = 1'b1;
                            kind_next    = KIND_STOP;
                            stop_id_next = ring_view.head;
                            slot_next    = '0;
                            last_next    = 1'b0;
                        end
                    end
                    OP_IF_FREE:
                    begin
                        if (!found_reg && hit)
                        begin
                            ring_ctl.tail = id_reg;
                            found_next    = 1'b1;
                            hit_slot_next = cnt_reg;
                        end
                    end
                    OP_STEAL:
                    begin
                        // Drop the taken slot: pull each later slot down, new id last.
                        if (take)
                        begin
                            ring_ctl.tail = at_end ? id_reg : ring_view.next;
                            found_next    = 1'b1;
                        end
                        if (state_reg == S_SCAN2 && cnt_reg == '0)
                        begin
                            strobe_next  = 1'b1;
                            kind_next    = KIND_STOP;
                            stop_id_next = ring_view.head;
                            slot_next    = '0;
                            last_next    = 1'b0;
                        end
                    end
                    default:
                    begin
                        ring_ctl.tail = ring_view.head;
                    end
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (at_end)
                begin
                    cnt_next = '0;
                    if (op_reg == OP_STEAL && !take)
                    begin
                        // Row full and left as it was: steal slot zero on a second pass.
                        state_next = S_SCAN2;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                strobe_next  = 1'b1;
                stop_id_next = '0;
                last_next    = 1'b1;
                slot_next    = '0;
                state_next   = S_IDLE;
                unique case (op_reg)
                    OP_RELEASE:
                    begin
                        kind_next = KIND_RELEASED;
                    end
                    OP_STOP_ALL:
                    begin
                        kind_next = KIND_PLACED;
                    end
                    OP_IF_FREE:
                    begin
                        kind_next = found_reg ? KIND_PLACED : KIND_REFUSED;
                        slot_next = found_reg ? SLOT_OUT_W'(hit_slot_reg) : '0;
                    end
                    OP_STEAL:
                    begin
                        kind_next = KIND_PLACED;
                        slot_next = SLOT_OUT_W'(CNT_LAST);
                    end
                    default:
                    begin
                        kind_next = KIND_PLACED;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_RELEASE;
            cnt_reg    <= '0;
            found_reg  <= 1'b0;
            mode_reg   <= MODE_STEAL;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            cnt_reg    <= cnt_next;
            found_reg  <= found_next;
            strobe_reg <= strobe_next;
            if (mode_we)
            begin
                mode_reg <= mode_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_slot_reg <= hit_slot_next;
        id_reg       <= id_next;
        kind_reg     <= kind_next;
        stop_id_reg  <= stop_id_next;
        slot_reg     <= slot_next;
        last_reg     <= last_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign strobe  = strobe_reg;
    assign kind    = kind_reg;
    assign stop_id = stop_id_reg;
    assign slot    = slot_reg;
    assign last    = last_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> state_reg == S_IDLE)
        else $error("final result shown while still busy");

    a_mid_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> kind == KIND_STOP)
        else $error("non-final result is not a stop");

    a_stop_live: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_STOP |-> stop_id != '0)
        else $error("stop issued for a free slot");

    a_pass2_steal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN2 && cnt_reg == '0 |-> op_reg == OP_STEAL && !found_reg)
        else $error("second pass outside steal of a full row");
`endif

endmodule

// File: rtl/voice_slot_allocator.sv
// Voice slot allocator: a row of SLOTS voice ids for one sound, 0 = free slot.
// Command channel: present func and voice_id with start high; the transaction
// is taken at a rising edge where start is high and busy is low. busy stays
// high until all results of that transaction are out.
// Config: play_mode is written by mode_we/mode_wdata; the user must write it
// only while busy is low, as the block itself leaves this unchecked.
// Results: each appears for one cycle with strobe high; last marks the final
// one of a transaction. Stops come first, then one placed/refused/released.
// The receiver cannot stall; every result must be taken in its strobe cycle.
// Timing: one slot is examined per cycle as the row rotates past a single
// comparator, and the final result follows the scan; a steal from a full
// row takes a second rotation. Busy drops in the cycle the final result
// shows, and a new transaction may be taken in that cycle.
// Reset: all slots free, play_mode steal-oldest, strobe low.
module voice_slot_allocator
    import vsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [ID_W-1:0]       voice_id,
    input  logic                  mode_we,
    input  logic [MODE_W-1:0]     mode_wdata,
    output logic                  strobe,
    output logic [KIND_W-1:0]     kind,
    output logic [ID_W-1:0]       stop_id,
    output logic [SLOT_OUT_W-1:0] slot,
    output logic                  last
);

    ring_ctrl_t ring_ctl;
    ring_view_t ring_view;

    vsa_slot_ring #(
        .SLOTS (SLOTS)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ring_ctl  (ring_ctl),
        .ring_view (ring_view)
    );

    vsa_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .voice_id   (voice_id),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .ring_view  (ring_view),
        .ring_ctl   (ring_ctl),
        .strobe     (strobe),
        .kind       (kind),
        .stop_id    (stop_id),
        .slot       (slot),
        .last       (last)
    );

endmodule
